### rtl/core/dcc_pkg.sv
`default_nettype none
package dcc_pkg;

  // day counts of the gregorian cycles
  localparam logic [18:0] D400 = 19'd146097;
  localparam logic [15:0] D100 = 16'd36524;
  localparam logic [10:0] D4   = 11'd1461;
  localparam logic [8:0]  D1   = 9'd365;

  localparam int MONTHS = 12;

  // whole 400-year cycles added so the shifted count is never negative
  localparam int unsigned K400 = 14700;

  // year offset that cancels the bias cycles, plus one for year numbering from 1
  localparam logic [15:0] YEAR_BIAS = 16'(32'sd1 - 32'sd400 * 32'(K400));

  // floor(2^48 / 146097): quotient estimate from bits 32:8 of the count
  localparam int RECIP_400_SHIFT = 40;
  localparam logic [30:0] RECIP_400 = 31'((64'd1 << 48) / 64'd146097);

  // ceil(2^26 / 1461): exact quotient for remainders up to one century
  localparam int RECIP_4_SHIFT = 26;
  localparam logic [15:0] RECIP_4 = 16'(((64'd1 << 26) + 64'd1460) / 64'd1461);

  // first day of each month, index 0 is january
  localparam logic [11:0][8:0] MSTART_COMMON = {
    9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
    9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
  };
  localparam logic [11:0][8:0] MSTART_LEAP = {
    9'd335, 9'd305, 9'd274, 9'd244, 9'd213, 9'd182,
    9'd152, 9'd121, 9'd91,  9'd60,  9'd31,  9'd0
  };

  // 400-year cycle index and day within the cycle
  typedef struct packed {
    logic [15:0] q;
    logic [17:0] r;
    logic        is_null;
  } front_t;

  // year and day of year
  typedef struct packed {
    logic [15:0] year;
    logic [8:0]  doy;
    logic        leap;
    logic        is_null;
  } cycle_t;

endpackage
`default_nettype wire

### rtl/core/dcc_req_if.sv
`default_nettype none
interface dcc_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] day_offset;

  modport source (output valid, output day_offset, input ready);
  modport sink   (input valid, input day_offset, output ready);
endinterface
`default_nettype wire

### rtl/core/dcc_rsp_if.sv
`default_nettype none
interface dcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic        is_null;

  modport source (output valid, output year, output month, output day, output is_null,
                  input ready);
  modport sink   (input valid, input year, input month, input day, input is_null,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/dcc_front.sv
`default_nettype none
module dcc_front #(
  parameter logic [32:0] ZBIAS = 33'd0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [31:0] day_offset,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      dcc_pkg::front_t    out_data
);

  logic        v1, v2, v3, v4;
  logic        rd1, rd2, rd3, rd4;
  logic [32:0] zz1, zz2, zz3;
  logic        n1, n2, n3;
  logic [15:0] qe2, qe3;
  logic [32:0] qd3;
  dcc_pkg::front_t s4;

  logic [33:0] off_ext;
  logic [32:0] zz1_next;
  logic [55:0] prod;
  logic [32:0] qd_next;
  logic [32:0] diff;
  logic [18:0] r0;
  dcc_pkg::front_t s4_next;

  assign rd4 = !v4 || out_ready;
  assign rd3 = !v3 || rd4;
  assign rd2 = !v2 || rd3;
  assign rd1 = !v1 || rd2;
  assign in_ready = rd1;

  // shift to a non-negative count from the start of the bias cycles
  assign off_ext  = {{2{day_offset[31]}}, day_offset};
  assign zz1_next = 33'(off_ext + {1'b0, ZBIAS});

  // quotient estimate, low by at most two
  assign prod = 56'(zz1[32:8]) * 56'(dcc_pkg::RECIP_400);

  assign qd_next = 33'(qe2) * 33'(dcc_pkg::D400);

  assign diff = zz3 - qd3;
  assign r0   = diff[18:0];

  always_comb begin
    s4_next.is_null = n3;
    if (r0 >= 19'(2 * dcc_pkg::D400)) begin
      s4_next.q = qe3 + 16'd2;
      s4_next.r = 18'(r0 - 19'(2 * dcc_pkg::D400));
    end else if (r0 >= dcc_pkg::D400) begin
      s4_next.q = qe3 + 16'd1;
      s4_next.r = 18'(r0 - dcc_pkg::D400);
    end else begin
      s4_next.q = qe3;
      s4_next.r = r0[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rd1) v1 <= in_valid;
      if (rd2) v2 <= v1;
      if (rd3) v3 <= v2;
      if (rd4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rd1) begin
      zz1 <= zz1_next;
      n1  <= (day_offset == 32'sh8000_0000);
    end
    if (rd2) begin
      zz2 <= zz1;
      qe2 <= prod[55:dcc_pkg::RECIP_400_SHIFT];
      n2  <= n1;
    end
    if (rd3) begin
      zz3 <= zz2;
      qe3 <= qe2;
      qd3 <= qd_next;
      n3  <= n2;
    end
    if (rd4) s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule
`default_nettype wire

### rtl/core/dcc_cycle.sv
`default_nettype none
module dcc_cycle (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire dcc_pkg::front_t in_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      dcc_pkg::cycle_t out_data
);

  logic        v5, v6, v7;
  logic        rd5, rd6, rd7;
  logic [15:0] y5, y6;
  logic [1:0]  c5, c6;
  logic [15:0] r5, r6;
  logic        n5, n6;
  logic [4:0]  f6;
  dcc_pkg::cycle_t s7;

  logic [1:0]  c_next;
  logic [15:0] r5_next;
  logic [15:0] y5_next;
  logic [31:0] fprod;
  logic [15:0] r2_full;
  logic [10:0] r2;
  logic [1:0]  a;
  logic [8:0]  doy;
  dcc_pkg::cycle_t s7_next;

  assign rd7 = !v7 || out_ready;
  assign rd6 = !v6 || rd7;
  assign rd5 = !v5 || rd6;
  assign in_ready = rd5;

  // centuries, the last day of a cycle stays in the fourth century
  assign c_next = 2'(in_data.r >= 18'(dcc_pkg::D100))
                + 2'(in_data.r >= 18'(2 * dcc_pkg::D100))
                + 2'(in_data.r >= 18'(3 * dcc_pkg::D100));
  assign r5_next = 16'(in_data.r - 18'(c_next) * 18'(dcc_pkg::D100));
  assign y5_next = 16'(in_data.q * 16'd400) + dcc_pkg::YEAR_BIAS + 16'(c_next) * 16'd100;

  // four-year groups within the century
  assign fprod = 32'(r5) * 32'(dcc_pkg::RECIP_4);

  assign r2_full = r6 - 16'(f6) * 16'(dcc_pkg::D4);
  assign r2      = r2_full[10:0];
  assign a = 2'(r2 >= 11'(dcc_pkg::D1))
           + 2'(r2 >= 11'(2 * dcc_pkg::D1))
           + 2'(r2 >= 11'(3 * dcc_pkg::D1));
  assign doy = 9'(r2 - 11'(a) * 11'(dcc_pkg::D1));

  always_comb begin
    s7_next.year    = y6 + {9'd0, f6, 2'b00} + 16'(a);
    s7_next.doy     = doy;
    // last year of a group, except a century year not divisible by 400
    s7_next.leap    = (a == 2'd3) && ((f6 != 5'd24) || (c6 == 2'd3));
    s7_next.is_null = n6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rd5) v5 <= in_valid;
      if (rd6) v6 <= v5;
      if (rd7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rd5) begin
      y5 <= y5_next;
      c5 <= c_next;
      r5 <= r5_next;
      n5 <= in_data.is_null;
    end
    if (rd6) begin
      y6 <= y5;
      c6 <= c5;
      r6 <= r5;
      f6 <= fprod[dcc_pkg::RECIP_4_SHIFT+4:dcc_pkg::RECIP_4_SHIFT];
      n6 <= n5;
    end
    if (rd7) s7 <= s7_next;
  end

  assign out_valid = v7;
  assign out_data  = s7;

endmodule
`default_nettype wire

### rtl/core/dcc_month.sv
`default_nettype none
module dcc_month (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire dcc_pkg::cycle_t in_data,
  dcc_rsp_if.source            rsp
);

  logic             v8;
  logic             rd8;
  logic [11:0][8:0] tab;
  logic [3:0]       midx;
  logic [8:0]       mstart;
  logic [15:0]      year_q;
  logic [3:0]       month_q;
  logic [4:0]       day_q;
  logic             null_q;

  assign rd8 = !v8 || rsp.ready;
  assign in_ready = rd8;

  assign tab = in_data.leap ? dcc_pkg::MSTART_LEAP : dcc_pkg::MSTART_COMMON;

  // last month whose first day is not past the day of year
  always_comb begin
    midx = 4'd0;
    for (int m = 1; m < dcc_pkg::MONTHS; m++) begin
      if (in_data.doy >= tab[m]) midx = 4'(m);
    end
  end

  assign mstart = tab[midx];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (rd8) begin
      v8 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd8) begin
      null_q <= in_data.is_null;
      if (in_data.is_null) begin
        year_q  <= 16'd0;
        month_q <= 4'd0;
        day_q   <= 5'd0;
      end else begin
        year_q  <= in_data.year;
        month_q <= midx + 4'd1;
        day_q   <= 5'(in_data.doy - mstart) + 5'd1;
      end
    end
  end

  assign rsp.valid   = v8;
  assign rsp.year    = year_q;
  assign rsp.month   = month_q;
  assign rsp.day     = day_q;
  assign rsp.is_null = null_q;

endmodule
`default_nettype wire

### rtl/core/day_count_to_civil_date.sv
`default_nettype none
// channel | role   | payload                                | transaction
// --------+--------+----------------------------------------+-------------------------
// req     | sink   | day_offset (s32, 0x80000000 = null)    | valid && ready at clk
// rsp     | source | year[15:0] month[3:0] day[4:0] is_null | valid && ready at clk
//
// one transaction per cycle in each direction while rsp is not stalled
// the result passes through a chain of registered stages: offset add, quotient
// multiply, back multiply, correction, century, group multiply, year split, month
// every stage holds its own valid bit, so bubbles close up under a stalled rsp
// and req stays ready while any stage ahead is empty
// rst is synchronous and clears the valid bits only
module day_count_to_civil_date #(
  parameter int EPOCH_YEAR = 2000
) (
  input wire logic  clk,
  input wire logic  rst,
  dcc_req_if.sink   req,
  dcc_rsp_if.source rsp
);

  // days from 1 january of year 1 to 1 january of the epoch year
  localparam int unsigned Y_PRE = EPOCH_YEAR - 1;
  localparam int unsigned Z0 = Y_PRE * 365 + Y_PRE / 4 - Y_PRE / 100 + Y_PRE / 400;

  // epoch shift plus the bias cycles that keep the count non-negative
  localparam logic [32:0] ZBIAS = 33'(64'(Z0) + 64'(dcc_pkg::K400) * 64'(dcc_pkg::D400));

  logic            front_valid;
  logic            front_ready;
  dcc_pkg::front_t front_data;
  logic            cycle_valid;
  logic            cycle_ready;
  dcc_pkg::cycle_t cycle_data;

  // 400-year cycle split, quotient by reciprocal with a two-step fixup
  dcc_front #(
    .ZBIAS(ZBIAS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .day_offset(req.day_offset),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // centuries, four-year groups and single years, with the leap flag
  dcc_cycle u_cycle (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_data  (front_data),
    .out_valid(cycle_valid),
    .out_ready(cycle_ready),
    .out_data (cycle_data)
  );

  // month table compare and the output register
  dcc_month u_month (
    .clk     (clk),
    .rst     (rst),
    .in_valid(cycle_valid),
    .in_ready(cycle_ready),
    .in_data (cycle_data),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire
